[hdl/sha256sb_pkg.sv]
// Shared types, constants and round functions for the single-block SHA-256 hasher.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package sha256sb_pkg;

    // Largest message that fits one padded block
    localparam logic [5:0] MAX_BYTES = 6'd55;
    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam int         BUF_WORDS = 14;
    localparam int         WIN_WORDS = 16;
    localparam int         DIG_WORDS = 8;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT,
        ST_ERROR
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic       store;     // input beat accepted
        logic       load;      // pad, load schedule window, clear buffer
        logic       round;     // one compression round
        logic       finalize;  // add initial hash
        logic [5:0] round_idx;
        logic [2:0] word_sel;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic overflowed;
    } t_dp_stat;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

endpackage

[hdl/sha256sb_ctrl.sv]
// Sequencer for the single-block SHA-256 hasher: byte intake, rounds, digest output.
// Depends on sha256sb_pkg; drives sha256sb_dp through t_dp_cmd.
`timescale 1ns / 1ps

module sha256sb_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_last,
    input  logic                   i_out_stall,
    input  sha256sb_pkg::t_dp_stat i_stat,
    output sha256sb_pkg::t_dp_cmd  o_cmd,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output logic [2:0]             o_word_index,
    output logic                   o_too_long,
    output logic                   o_last_word
);
    import sha256sb_pkg::*;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       out_take;

    // State and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign out_take = !i_out_stall;

    // Next state and commands
    always_comb begin
        n_state            = r_state;
        n_cnt              = r_cnt;
        o_cmd              = '0;
        o_cmd.round_idx    = r_cnt;
        o_cmd.word_sel     = r_cnt[2:0];
        o_in_stall         = 1'b1;
        o_out_valid        = 1'b0;
        o_word_index       = r_cnt[2:0];
        o_too_long         = 1'b0;
        o_last_word        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    if (i_last) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = '0;
                n_state    = i_stat.overflowed ? ST_ERROR : ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_cnt       = r_cnt + 6'd1;
                if (r_cnt == LAST_ROUND) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                o_cmd.finalize = 1'b1;
                n_cnt          = '0;
                n_state        = ST_EMIT;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                o_last_word = (r_cnt[2:0] == LAST_WORD_IDX);
                if (out_take) begin
                    if (r_cnt[2:0] == LAST_WORD_IDX) begin
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 6'd1;
                    end
                end
            end
            ST_ERROR: begin
                o_out_valid  = 1'b1;
                o_too_long   = 1'b1;
                o_last_word  = 1'b1;
                o_word_index = '0;
                if (out_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

endmodule

[hdl/sha256sb_dp.sv]
// Datapath of the single-block SHA-256 hasher: byte buffer, schedule window,
// working variables and digest. Depends on sha256sb_pkg; driven by sha256sb_ctrl.
`timescale 1ns / 1ps

module sha256sb_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sha256sb_pkg::t_dp_cmd  i_cmd,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_byte_valid,
    output sha256sb_pkg::t_dp_stat o_stat,
    output logic [31:0]            o_word
);
    import sha256sb_pkg::*;

    logic [31:0] r_blk [BUF_WORDS];
    logic [5:0]  r_byte_count;
    logic        r_overflowed;
    logic [31:0] r_w [WIN_WORDS];
    logic [31:0] r_v [DIG_WORDS];

    logic [4:0]  byte_sh;
    logic [31:0] byte_word;
    logic [31:0] pad_word;
    logic        room;
    logic [31:0] w_next;
    logic [31:0] t1, t2;

    // Position of the next byte inside its big-endian word
    assign byte_sh   = {~r_byte_count[1:0], 3'b000};
    assign byte_word = 32'(i_data_byte) << byte_sh;
    assign pad_word  = 32'(PAD_BYTE) << byte_sh;
    assign room      = !r_overflowed && (r_byte_count < MAX_BYTES);

    // Round and schedule arithmetic
    assign w_next = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
    assign t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + ROUND_K[i_cmd.round_idx] + r_w[0];
    assign t2 = big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // Byte buffer, count and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUF_WORDS; i++) begin
                r_blk[i] <= '0;
            end
            r_byte_count <= '0;
            r_overflowed <= 1'b0;
        end else if (i_cmd.load) begin
            for (int i = 0; i < BUF_WORDS; i++) begin
                r_blk[i] <= '0;
            end
            r_byte_count <= '0;
            r_overflowed <= 1'b0;
        end else if (i_cmd.store && i_byte_valid) begin
            if (room) begin
                for (int i = 0; i < BUF_WORDS; i++) begin
                    if (r_byte_count[5:2] == 4'(i)) begin
                        r_blk[i] <= r_blk[i] | byte_word;
                    end
                end
                r_byte_count <= r_byte_count + 6'd1;
            end else begin
                r_overflowed <= 1'b1;
            end
        end
    end

    // Schedule window: padded block on load, one new word per round
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < BUF_WORDS; i++) begin
                r_w[i] <= (r_byte_count[5:2] == 4'(i)) ? (r_blk[i] | pad_word) : r_blk[i];
            end
            r_w[14] <= '0;
            r_w[15] <= {23'd0, r_byte_count, 3'b000};
        end else if (i_cmd.round) begin
            for (int i = 0; i < WIN_WORDS - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_next;
        end
    end

    // Working variables; they hold the digest after finalize
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < DIG_WORDS; i++) begin
                r_v[i] <= INIT_H[i];
            end
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end else if (i_cmd.finalize) begin
            for (int i = 0; i < DIG_WORDS; i++) begin
                r_v[i] <= r_v[i] + INIT_H[i];
            end
        end
    end

    assign o_stat.overflowed = r_overflowed;
    assign o_word            = r_v[i_cmd.word_sel];

endmodule

[hdl/sha256_single_block_hasher.sv]
// Single-block SHA-256 hasher. Bytes are taken one per cycle while idle.
// After the last input beat the block is padded and loaded, compressed round by round
// in a single round unit and the initial hash added; eight digest beats then follow,
// one per cycle when not stalled. A too-long message goes from the load straight to
// a single error beat. Input is stalled meanwhile. Reset (synchronous, active low)
// clears the buffer, byte count, overflow flag and the sequencer.
`timescale 1ns / 1ps

module sha256_single_block_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_word,
    output logic [2:0]  o_word_index,
    output logic        o_too_long,
    output logic        o_last_word
);
    import sha256sb_pkg::*;

    t_dp_cmd     cmd;
    t_dp_stat    stat;
    logic [31:0] dp_word;

    sha256sb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last       (i_last),
        .i_out_stall  (i_out_stall),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_word_index (o_word_index),
        .o_too_long   (o_too_long),
        .o_last_word  (o_last_word)
    );

    sha256sb_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .o_stat       (stat),
        .o_word       (dp_word)
    );

    // Error beat carries a zero word
    assign o_hash_word = o_too_long ? 32'd0 : dp_word;

endmodule
